>>> sv/gpb_pkg.sv
package gpb_pkg;

  // linear values are 0.16 with one guard bit, so 1.0 is held exactly
  localparam int LIN_W = 17;
  // a blended colour sum may reach 2.0
  localparam int Y_W = 18;
  localparam int KA_W = 9;
  localparam int LANES = 4;
  localparam int ALPHA_LANE = 3;

  localparam logic [LIN_W-1:0] LIN_ONE = 17'd65536;
  localparam logic [KA_W-1:0] KA_ONE = 9'd256;

  typedef logic [LIN_W-1:0] lin_t;
  typedef logic [Y_W-1:0] ylin_t;
  typedef logic [KA_W-1:0] ka_t;
  typedef logic [LIN_W-1:0] lin_tab_t [256];

  // colour byte to linear light: c^2 / 255^2, rounded
  function automatic lin_tab_t build_colour_lin();
    lin_tab_t tab;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(i) * longint'(i) * 64'd65536 + 64'd32512) / 64'd65025;
      tab[i] = v[LIN_W-1:0];
    end
    return tab;
  endfunction

  // alpha byte to linear: a / 255, rounded
  function automatic lin_tab_t build_alpha_lin();
    lin_tab_t tab;
    longint unsigned v;
    for (int i = 0; i < 256; i++) begin
      v = (longint'(i) * 64'd65536 + 64'd127) / 64'd255;
      tab[i] = v[LIN_W-1:0];
    end
    return tab;
  endfunction

  // smallest linear value that rounds up to colour code n
  // (ceil(((2n-1)*128)^2 / 65025)), zero for code zero
  function automatic lin_tab_t build_sqrt_thr();
    lin_tab_t tab;
    longint unsigned t;
    longint unsigned v;
    tab[0] = '0;
    for (int n = 1; n < 256; n++) begin
      t = longint'(2 * n - 1) * 64'd128;
      v = (t * t + 64'd65024) / 64'd65025;
      tab[n] = v[LIN_W-1:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t COLOUR_LIN = build_colour_lin();
  localparam lin_tab_t ALPHA_LIN = build_alpha_lin();
  localparam lin_tab_t SQRT_THR = build_sqrt_thr();

endpackage

>>> sv/gamma2_premultiplied_pixel_blend_top.sv
// channel   | ports                                   | direction | handshake
// ----------+-----------------------------------------+-----------+------------------
// in        | in_valid in_stall in_src_pixel in_dst_pixel | sink  | valid / stall
// out       | out_valid out_stall out_pixel           | source    | valid / stall
// cfg       | cfg_valid cfg_ready cfg_const_alpha     | sink      | valid / ready
//
// one pixel per clock sustained while out_stall is low
// stages: byte-to-linear lookup, constant alpha scale, blend multiply,
// then the square-root code search split over two stages (high and low nibble)
// synchronous active-low reset clears every stage valid bit and sets const alpha to 1.0
// each stage moves when the stage after it is empty or moving, so bubbles close up
// and a stalled result holds while earlier stages keep filling
module gamma2_premultiplied_pixel_blend_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_src_pixel,
  input  logic [31:0]          in_dst_pixel,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_pixel,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  gpb_pkg::ka_t         cfg_const_alpha
);
  import gpb_pkg::*;

  // configuration register, to be written only while idle; the block itself does not enforce this
  ka_t const_alpha_r;
  ka_t k_sat;

  // stage valid bits and advance strobes
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;

  // stage 1: linear source and destination, lanes B G R A
  lin_t s1_r [LANES];
  lin_t s1_nxt [LANES];
  lin_t d1_r [LANES];
  lin_t d1_nxt [LANES];

  // stage 2: source scaled by const alpha
  lin_t s2_r [LANES];
  lin_t s2_nxt [LANES];
  lin_t d2_r [LANES];

  // stage 3: blended linear values
  ylin_t y3_r [LANES];
  ylin_t y3_nxt [LANES];

  // stage 4: colour code high nibble, alpha byte done
  logic [7:0] n4_r [3];
  logic [7:0] n4_nxt [3];
  ylin_t y4_r [3];
  logic [7:0] a4_r;
  logic [7:0] a4_nxt;

  // stage 5: output register
  logic [31:0] out_pixel_r;
  logic [31:0] out_pixel_nxt;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_alpha_r <= KA_ONE;
    end else if (cfg_valid && cfg_ready) begin
      const_alpha_r <= cfg_const_alpha;
    end
  end

  // anything above 1.0 acts as 1.0
  assign k_sat = (const_alpha_r > KA_ONE) ? KA_ONE : const_alpha_r;

  // ------------------------------------------------------------- flow control
  assign adv5 = !v5_r || !out_stall;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_stall  = !adv1;
  assign out_valid = v5_r;
  assign out_pixel = out_pixel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
      if (adv4) begin
        v4_r <= v3_r;
      end
      if (adv5) begin
        v5_r <= v4_r;
      end
    end
  end

  // --------------------------------------------------- stage 1: to linear
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (i == ALPHA_LANE) begin
        s1_nxt[i] = ALPHA_LIN[in_src_pixel[8*i +: 8]];
        d1_nxt[i] = ALPHA_LIN[in_dst_pixel[8*i +: 8]];
      end else begin
        s1_nxt[i] = COLOUR_LIN[in_src_pixel[8*i +: 8]];
        d1_nxt[i] = COLOUR_LIN[in_dst_pixel[8*i +: 8]];
      end
    end
  end

  // ------------------------------------------- stage 2: const alpha scale
  always_comb begin
    logic [25:0] prod;
    for (int i = 0; i < LANES; i++) begin
      prod = 26'(s1_r[i]) * 26'(k_sat) + 26'd128;
      s2_nxt[i] = prod[24:8];
    end
  end

  // ------------------------------- stage 3: (1 - src alpha) * dst + src
  always_comb begin
    lin_t inv_a;
    logic [34:0] prod;
    inv_a = LIN_ONE - s2_r[ALPHA_LANE];
    for (int i = 0; i < LANES; i++) begin
      prod = 35'(inv_a) * 35'(d2_r[i]) + 35'd32768;
      y3_nxt[i] = Y_W'(prod[34:16]) + Y_W'(s2_r[i]);
    end
  end

  // ------------- stage 4: sqrt search upper nibble, alpha back to a byte
  always_comb begin
    logic [7:0] n;
    logic [7:0] cand;
    logic [25:0] aprod;
    for (int c = 0; c < 3; c++) begin
      n = '0;
      for (int b = 7; b >= 4; b--) begin
        cand = n | (8'd1 << b);
        if (y3_r[c] >= Y_W'(SQRT_THR[cand])) begin
          n = cand;
        end
      end
      n4_nxt[c] = n;
    end
    // alpha: round(y * 255 / 65536), saturated
    aprod = (26'(y3_r[ALPHA_LANE]) << 8) - 26'(y3_r[ALPHA_LANE]) + 26'd32768;
    a4_nxt = (aprod[25:16] > 10'd255) ? 8'hFF : aprod[23:16];
  end

  // ------------------------------- stage 5: sqrt search lower nibble
  always_comb begin
    logic [7:0] n;
    logic [7:0] cand;
    out_pixel_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      n = n4_r[c];
      for (int b = 3; b >= 0; b--) begin
        cand = n | (8'd1 << b);
        if (y4_r[c] >= Y_W'(SQRT_THR[cand])) begin
          n = cand;
        end
      end
      out_pixel_nxt[8*c +: 8] = n;
    end
    out_pixel_nxt[31:24] = a4_r;
  end

  // ------------------------------------------------------- datapath regs
  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_r <= s1_nxt;
      d1_r <= d1_nxt;
    end
    if (adv2) begin
      s2_r <= s2_nxt;
      d2_r <= d1_r;
    end
    if (adv3) begin
      y3_r <= y3_nxt;
    end
    if (adv4) begin
      n4_r <= n4_nxt;
      a4_r <= a4_nxt;
      for (int c = 0; c < 3; c++) begin
        y4_r[c] <= y3_r[c];
      end
    end
    if (adv5) begin
      out_pixel_r <= out_pixel_nxt;
    end
  end

  // ------------------------------------------------------------ checks
  // an accepted request lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted request missing from stage 1");

  // a blocked output must not let stage 4 drain
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && out_stall && v4_r |=> v4_r && v5_r)
    else $error("pipeline item lost under stall");

  // a config write takes effect on the next cycle
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> const_alpha_r == $past(cfg_const_alpha))
    else $error("const alpha write not taken");

  // blended alpha never exceeds 1.0
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> y3_r[ALPHA_LANE] <= Y_W'(LIN_ONE))
    else $error("blended alpha above one");

endmodule

>>> tb/testbench.sv
module testbench;

  import gpb_pkg::*;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n;

  // pixel request channel
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_src_pixel;
  logic [31:0] in_dst_pixel;

  // blended pixel channel, stall starts low so the port is known from time zero
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pixel;

  // constant alpha register port
  logic        cfg_valid;
  logic        cfg_ready;
  ka_t         cfg_const_alpha;

  always #5 clk = ~clk;

  gamma2_premultiplied_pixel_blend_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_src_pixel    (in_src_pixel),
    .in_dst_pixel    (in_dst_pixel),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel       (out_pixel),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_const_alpha (cfg_const_alpha)
  );

  // ---------------------------------------------------------------------------
  // blend predictor, pure integer math at the block's fixed-point widths
  // ---------------------------------------------------------------------------

  // our copy of the opacity register, reset value is 1.0
  ka_t opacity = KA_ONE;

  // colour byte to linear light, c^2/255^2 in 0.16 rounded half up
  function automatic lin_t colour_to_light(logic [7:0] c);
    longint unsigned v;
    v = (longint'(c) * longint'(c) * 65536 + 32512) / 65025;
    return lin_t'(v);
  endfunction

  // alpha byte to linear, a/255 in 0.16 rounded half up
  function automatic lin_t alpha_to_light(logic [7:0] a);
    longint unsigned v;
    v = (longint'(a) * 65536 + 127) / 255;
    return lin_t'(v);
  endfunction

  // multiply by the 1.8 opacity, rounded half up
  function automatic lin_t fade(lin_t x, longint unsigned k);
    longint unsigned v;
    v = (longint'(x) * k + 128) / 256;
    return lin_t'(v);
  endfunction

  // source over destination; a colour sum may reach 2.0 for bad premultiply
  function automatic ylin_t over(lin_t s, lin_t sa, lin_t d);
    longint unsigned v;
    v = ((65536 - longint'(sa)) * longint'(d) + 32768) / 65536 + longint'(s);
    return ylin_t'(v);
  endfunction

  // largest code n with n - 1/2 <= 255*sqrt(y), so round half up and cap at 255
  function automatic logic [7:0] light_to_colour(ylin_t y);
    longint unsigned rhs;
    longint unsigned t;
    logic [7:0] code;
    rhs = longint'(y) * 65025;
    code = 8'd0;
    for (int n = 1; n <= 255; n++) begin
      t = longint'(2 * n - 1) * 128;
      if (t * t <= rhs) code = 8'(n);
      else break;
    end
    return code;
  endfunction

  // 255*y rounded half up, saturated
  function automatic logic [7:0] light_to_alpha(ylin_t y);
    longint unsigned v;
    v = (longint'(y) * 255 + 32768) / 65536;
    return (v > 255) ? 8'hff : 8'(v);
  endfunction

  // whole ARGB blend for one request at opacity ka
  function automatic logic [31:0] blend_pixel(logic [31:0] src, logic [31:0] dst, ka_t ka);
    longint unsigned k;
    lin_t sa;
    lin_t s;
    lin_t d;
    logic [31:0] px;
    // opacity above 1.0 acts as 1.0
    k = (ka > KA_ONE) ? 256 : longint'(ka);
    sa = fade(alpha_to_light(src[31:24]), k);
    px[31:24] = light_to_alpha(over(sa, sa, alpha_to_light(dst[31:24])));
    for (int lane = 0; lane < 3; lane++) begin
      s = fade(colour_to_light(src[lane*8 +: 8]), k);
      d = colour_to_light(dst[lane*8 +: 8]);
      px[lane*8 +: 8] = light_to_colour(over(s, sa, d));
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // blended pixels still owed by the block, oldest first
  // ---------------------------------------------------------------------------
  logic [31:0] owed_pixels[$];
  int          mismatches = 0;
  bit          calm = 1'b0;      // no idling on either side in the closing stretch

  task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch: %s, expected %08h, got %08h", $time, what, want, got);
  endtask

  // result checker, samples at the edge where a result is taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (owed_pixels.size() == 0) begin
        flag_mismatch("result with no request pending", 32'h0, out_pixel);
      end else begin
        if (out_pixel !== owed_pixels[0])
          flag_mismatch("out_pixel", owed_pixels[0], out_pixel);
        void'(owed_pixels.pop_front());
      end
    end
  end

  // receiver back-pressure in random bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 11);
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // one request; the typed-in value wins over the predictor where given
  task automatic send_request(logic [31:0] src, logic [31:0] dst, bit known, logic [31:0] want);
    // random sender gap, valid stays high otherwise so requests go back to back
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_src_pixel <= src;
    in_dst_pixel <= dst;
    do @(posedge clk); while (in_stall);
    owed_pixels.push_back(known ? want : blend_pixel(src, dst, opacity));
  endtask

  // stop sending and wait until every owed pixel is back
  task automatic drain;
    in_valid <= 1'b0;
    while (owed_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic set_opacity(ka_t v);
    cfg_valid <= 1'b1;
    cfg_const_alpha <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    opacity = v;
  endtask

  // random byte at or below a bound
  function automatic logic [7:0] byte_upto(logic [7:0] hi);
    return 8'($urandom_range(0, hi));
  endfunction

  // one of the corner byte values
  function automatic logic [7:0] corner_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h01;
      default: return 8'hfe;
    endcase
  endfunction

  // source texel: mostly properly premultiplied, some corner and some garbage
  function automatic logic [31:0] pick_source();
    logic [7:0] a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        a = 8'($urandom_range(0, 255));
        return {a, byte_upto(a), byte_upto(a), byte_upto(a)};
      end
      5: return {8'hff, byte_upto(8'hff), byte_upto(8'hff), byte_upto(8'hff)};
      6: return {corner_byte(), corner_byte(), corner_byte(), corner_byte()};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_dest();
    if ($urandom_range(0, 5) == 0)
      return {corner_byte(), corner_byte(), corner_byte(), corner_byte()};
    return $urandom();
  endfunction

  // directed rows at reset opacity; known rows carry a value read straight off the math
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic        known;
    logic [31:0] want;
  } probe_t;

  localparam int NPROBES = 22;
  localparam probe_t PROBES [NPROBES] = '{
    // all zero in, all zero out
    '{32'h00000000, 32'h00000000, 1'b1, 32'h00000000},
    // opaque white source covers anything
    '{32'hffffffff, 32'h00000000, 1'b1, 32'hffffffff},
    '{32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff},
    // empty source leaves white destination alone
    '{32'h00000000, 32'hffffffff, 1'b1, 32'hffffffff},
    // colour above alpha; the sum reaches 1.0 or passes it and saturates
    '{32'h00ffffff, 32'hffffffff, 1'b1, 32'hffffffff},
    '{32'h00ff0000, 32'h00000000, 1'b1, 32'h00ff0000},
    '{32'h00ffffff, 32'h00000000, 1'b1, 32'h00ffffff},
    // opaque black source wipes the destination colour; last row: empty source over opaque black
    '{32'hff000000, 32'hffffffff, 1'b1, 32'hff000000},
    '{32'hff000000, 32'h00000000, 1'b1, 32'hff000000},
    '{32'h00000000, 32'hff000000, 1'b1, 32'hff000000},
    // mid values and rounding edges, predicted
    '{32'h80808080, 32'h80808080, 1'b0, 32'h0},
    '{32'h01010101, 32'hfefefefe, 1'b0, 32'h0},
    '{32'h7f7f7f7f, 32'h80808080, 1'b0, 32'h0},
    '{32'hff800000, 32'h00ff00ff, 1'b0, 32'h0},
    '{32'h40102030, 32'hc0a0b0f0, 1'b0, 32'h0},
    '{32'h01000000, 32'h00ffffff, 1'b0, 32'h0},
    '{32'haa555555, 32'h55aaaaaa, 1'b0, 32'h0},
    '{32'h55aaaaaa, 32'h12345678, 1'b0, 32'h0},
    '{32'hfe010203, 32'h01fefdfc, 1'b0, 32'h0},
    '{32'h80ff0000, 32'h80000000, 1'b0, 32'h0},
    '{32'h01ffffff, 32'hffffffff, 1'b0, 32'h0},
    '{32'hfffffffe, 32'h01010101, 1'b0, 32'h0}
  };

  // opacity sweep, one per phase: extremes, above-one saturation, mid values;
  // the random slot is filled in at run time and the last phase runs at 1.0
  localparam int NPHASES = 9;
  localparam int PHASE_REQS = 72;
  localparam ka_t SWEEP [NPHASES] = '{
    9'd0, 9'd511, 9'd1, 9'd257, 9'd0, 9'd128, 9'd255, 9'd384, 9'd256
  };
  localparam int RANDOM_PHASE = 4;

  initial begin
    ka_t ka;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_src_pixel = '0;
    in_dst_pixel = '0;
    cfg_valid = 1'b0;
    cfg_const_alpha = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at reset opacity
    for (int i = 0; i < NPROBES; i++)
      send_request(PROBES[i].src, PROBES[i].dst, PROBES[i].known, PROBES[i].want);

    // random part, one opacity per phase, written only once the block is empty
    for (int p = 0; p < NPHASES; p++) begin
      drain();
      ka = (p == RANDOM_PHASE) ? ka_t'($urandom_range(2, 254)) : SWEEP[p];
      set_opacity(ka);
      if (p == NPHASES - 1) calm = 1'b1;
      for (int i = 0; i < PHASE_REQS; i++)
        send_request(pick_source(), pick_dest(), 1'b0, 32'h0);
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
